FILE: rtl/core/c8alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared types for the 8-bit ALU with flags: operation codes and the packed
// layouts of one input item and one result item.
// ----------------------------------------------------------------------------
package c8alu_pkg;

	localparam int unsigned IN_BITS   = 28;
	localparam int unsigned IN_BYTES  = 4;
	localparam int unsigned OUT_BITS  = 20;
	localparam int unsigned OUT_BYTES = 3;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBC  = 5'd3,
		OP_AND  = 5'd4,
		OP_XOR  = 5'd5,
		OP_OR   = 5'd6,
		OP_CP   = 5'd7,
		OP_INC  = 5'd8,
		OP_DEC  = 5'd9,
		OP_RLCA = 5'd10,
		OP_RLA  = 5'd11,
		OP_RRCA = 5'd12,
		OP_RRA  = 5'd13,
		OP_RLC  = 5'd14,
		OP_RL   = 5'd15,
		OP_RRC  = 5'd16,
		OP_RR   = 5'd17,
		OP_SLA  = 5'd18,
		OP_SRA  = 5'd19,
		OP_SRL  = 5'd20,
		OP_SWAP = 5'd21,
		OP_DAA  = 5'd22,
		OP_CPL  = 5'd23,
		OP_CCF  = 5'd24,
		OP_SCF  = 5'd25,
		OP_BIT  = 5'd26,
		OP_SET  = 5'd27,
		OP_RES  = 5'd28
	} op_t;

	// rotate / shift kinds of the shared shifter
	typedef enum logic [2:0] {
		SH_RLC = 3'd0,
		SH_RL  = 3'd1,
		SH_RRC = 3'd2,
		SH_RR  = 3'd3,
		SH_SLA = 3'd4,
		SH_SRA = 3'd5,
		SH_SRL = 3'd6
	} shift_kind_t;

	// first field in the highest bits, so members run from the top down
	typedef struct packed {
		logic       carry_in;
		logic       half_in;
		logic       subtract_in;
		logic       zero_in;
		logic [2:0] bit_index;
		logic [7:0] operand_in;
		logic [7:0] accumulator_in;
		op_t        op;
	} in_item_t;

	typedef struct packed {
		logic       carry_out;
		logic       half_out;
		logic       subtract_out;
		logic       zero_out;
		logic [7:0] operand_out;
		logic [7:0] accumulator_out;
	} res_item_t;

endpackage

FILE: rtl/core/cpu_8bit_alu_with_flags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_unit
// 8-bit ALU with Z/N/H/C flags behind an input register and a result register.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register; its result is loaded into the
//   result register when that register is empty or being drained.
// Throughput: one item per cycle unless the output stalls; a waiting result lets the input
//   take one more item into an empty input register, then holds the input off until the result is taken.
// Reset: arst_n clears both stage valid bits; payload registers are not reset.
module cpu_8bit_alu_with_flags_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[4:0], accumulator_in[12:5], operand_in[20:13], bit_index[23:21],
	// zero_in[24], subtract_in[25], half_in[26], carry_in[27], zero[31:28]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// accumulator_out[7:0], operand_out[15:8], zero_out[16], subtract_out[17],
	// half_out[18], carry_out[19], zero[23:20]
	output logic [23:0] m_axis_tdata
);
	import c8alu_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	res_item_t res_s2;
	res_item_t res_comb;
	logic      load_s2;
	logic      adv_s1;

	// output stage takes a new item when empty or being drained
	assign load_s2       = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && load_s2;
	assign s_axis_tready = !valid_s1 || load_s2;

	c8alu_datapath u_datapath (
		.item (item_s1),
		.res  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item_t'(s_axis_tdata[IN_BITS-1:0]);
		end
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, res_s2};

	// unused top bits of the input word
	logic unused_tdata;
	assign unused_tdata = ^s_axis_tdata[IN_BYTES*8-1:IN_BITS];

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("advancing item did not reach the result register");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |=> valid_s2 && $stable(res_s2))
		else $error("stalled result was lost or changed");

	a_full_s1_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(item_s1))
		else $error("held input item was overwritten");

endmodule

FILE: rtl/core/c8alu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8alu_datapath
// Combinational ALU: arithmetic, logic, rotates, shifts, swap, decimal adjust,
// complement, carry-flag and bit operations on one registered input item.
// ----------------------------------------------------------------------------
module c8alu_datapath (
	input  c8alu_pkg::in_item_t  item,
	output c8alu_pkg::res_item_t res
);
	import c8alu_pkg::*;

	// returns {carry, result}
	function automatic logic [8:0] shift_byte(input shift_kind_t kind, input logic [7:0] v,
			input logic cin);
		logic [8:0] r;
		unique case (kind)
			SH_RLC:  r = {v[7], v[6:0], v[7]};
			SH_RL:   r = {v[7], v[6:0], cin};
			SH_RRC:  r = {v[0], v[0], v[7:1]};
			SH_RR:   r = {v[0], cin, v[7:1]};
			SH_SLA:  r = {v[7], v[6:0], 1'b0};
			SH_SRA:  r = {v[0], v[7], v[7:1]};
			default: r = {v[0], 1'b0, v[7:1]};
		endcase
		return r;
	endfunction

	logic [7:0] a;
	logic [7:0] b;
	logic       cin_arith;
	logic [8:0] sum9;
	logic [4:0] sum_lo;
	logic [8:0] diff9;
	logic [4:0] diff_lo;
	logic [8:0] sh_acc;
	logic [8:0] sh_opd;
	logic       daa_hi;
	logic [7:0] daa_t1;
	logic       daa_lo;
	logic [7:0] daa_add;
	logic [7:0] daa_sub;
	logic [7:0] daa_res;
	logic [7:0] bit_mask;

	assign a = item.accumulator_in;
	assign b = item.operand_in;

	// carry only joins in for the with-carry forms
	assign cin_arith = (item.op == OP_ADC || item.op == OP_SBC) ? item.carry_in : 1'b0;

	assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cin_arith};
	assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_arith};
	assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, cin_arith};
	assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_arith};

	assign sh_acc = shift_byte(shift_kind_t'(3'(item.op - OP_RLCA)), a, item.carry_in);
	assign sh_opd = shift_byte(shift_kind_t'(3'(item.op - OP_RLC)), b, item.carry_in);

	// decimal adjust: the upper correction is decided on the raw accumulator
	assign daa_hi  = item.carry_in || (a > 8'h99);
	assign daa_t1  = a + (daa_hi ? 8'h60 : 8'h00);
	assign daa_lo  = item.half_in || (daa_t1[3:0] > 4'd9);
	assign daa_add = daa_t1 + (daa_lo ? 8'h06 : 8'h00);
	assign daa_sub = a - (item.carry_in ? 8'h60 : 8'h00) - (item.half_in ? 8'h06 : 8'h00);
	assign daa_res = item.subtract_in ? daa_sub : daa_add;

	assign bit_mask = 8'd1 << item.bit_index;

	always_comb begin
		res.accumulator_out = a;
		res.operand_out     = b;
		res.zero_out        = item.zero_in;
		res.subtract_out    = item.subtract_in;
		res.half_out        = item.half_in;
		res.carry_out       = item.carry_in;
		unique case (item.op) inside
			OP_ADD, OP_ADC: begin
				res.accumulator_out = sum9[7:0];
				res.zero_out        = (sum9[7:0] == 8'd0);
				res.subtract_out    = 1'b0;
				res.half_out        = sum_lo[4];
				res.carry_out       = sum9[8];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				if (item.op != OP_CP) begin
					res.accumulator_out = diff9[7:0];
				end
				res.zero_out     = (diff9[7:0] == 8'd0);
				res.subtract_out = 1'b1;
				res.half_out     = diff_lo[4];
				res.carry_out    = diff9[8];
			end
			OP_AND, OP_XOR, OP_OR: begin
				if (item.op == OP_AND) begin
					res.accumulator_out = a & b;
				end else if (item.op == OP_XOR) begin
					res.accumulator_out = a ^ b;
				end else begin
					res.accumulator_out = a | b;
				end
				res.zero_out     = (res.accumulator_out == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = (item.op == OP_AND);
				res.carry_out    = 1'b0;
			end
			OP_INC: begin
				res.operand_out  = b + 8'd1;
				res.zero_out     = (b == 8'hFF);
				res.subtract_out = 1'b0;
				res.half_out     = (b[3:0] == 4'hF);
			end
			OP_DEC: begin
				res.operand_out  = b - 8'd1;
				res.zero_out     = (b == 8'h01);
				res.subtract_out = 1'b1;
				res.half_out     = (b[3:0] == 4'h0);
			end
			OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
				res.accumulator_out = sh_acc[7:0];
				res.zero_out        = 1'b0;
				res.subtract_out    = 1'b0;
				res.half_out        = 1'b0;
				res.carry_out       = sh_acc[8];
			end
			OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
				res.operand_out  = sh_opd[7:0];
				res.zero_out     = (sh_opd[7:0] == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b0;
				res.carry_out    = sh_opd[8];
			end
			OP_SWAP: begin
				res.operand_out  = {b[3:0], b[7:4]};
				res.zero_out     = (b == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b0;
				res.carry_out    = 1'b0;
			end
			OP_DAA: begin
				res.accumulator_out = daa_res;
				res.zero_out        = (daa_res == 8'd0);
				res.half_out        = 1'b0;
				res.carry_out       = item.subtract_in ? item.carry_in : daa_hi;
			end
			OP_CPL: begin
				res.accumulator_out = ~a;
				res.subtract_out    = 1'b1;
				res.half_out        = 1'b1;
			end
			OP_CCF, OP_SCF: begin
				res.subtract_out = 1'b0;
				res.half_out     = 1'b0;
				res.carry_out    = (item.op == OP_SCF) | ~item.carry_in;
			end
			OP_BIT: begin
				res.zero_out     = ~b[item.bit_index];
				res.subtract_out = 1'b0;
				res.half_out     = 1'b1;
			end
			OP_SET: begin
				res.operand_out = b | bit_mask;
			end
			OP_RES: begin
				res.operand_out = b & ~bit_mask;
			end
			default: begin
				// undefined codes pass everything through
				res.accumulator_out = a;
			end
		endcase
	end

endmodule
